[sv/cmf_pkg.sv]
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types, constants and the arctangent table of the circular mean block.
// ----------------------------------------------------------------------------
package cmf_pkg;

    // default frame limit and cordic depth
    localparam int MAX_FRAME_DEF     = 4096;
    localparam int CORDIC_STAGES_DEF = 16;

    // datapath widths of the cordic cells
    localparam int XY_W = 60;
    localparam int Z_W  = 34;

    // 1/K in Q30.30
    localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(652032874);

    // reset value of the circle size, 360.0 in Q16.16
    localparam logic [31:0] RANGE_RESET = 32'd23592960;

    // one beat travelling along the cordic row
    typedef struct packed {
        logic                   valid;
        logic                   vec;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cord;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[sv/circular_mean_frame.sv]
// ----------------------------------------------------------------------------
// circular_mean_frame
// Circular mean of a frame of Q16.16 angle samples on a circle of range_max.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A sample passes the accept cycle, a
// one-bit-per-cycle divider (sample mod range, then the phase fraction) and
// the row of cordic cells before the next beat is accepted; with a zero range
// the divider is skipped, and a sample past the frame limit is dropped. A
// last sample adds a check cycle, one more pass through the cordic row for
// atan2 (skipped when both sums are zero), a multiply cycle and a hand-off
// cycle before the mean is moved to the output register, which holds it until
// taken while the next frame already starts; the hand-off waits while that
// register still holds an untaken mean.
module circular_mean_frame #(
    parameter int MAX_FRAME     = cmf_pkg::MAX_FRAME_DEF,
    parameter int CORDIC_STAGES = cmf_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [31:0] i_sample,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_mean
);
    import cmf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MOD  = 8'b0000_0010,
        S_FRAC = 8'b0000_0100,
        S_ROT  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_VEC  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    logic [31:0]         r_range;
    logic signed [31:0]  r_sin;
    logic signed [31:0]  r_cos;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_last;
    logic                r_neg;
    logic                r_flip;
    logic [4:0]          r_step;
    logic [31:0]         r_rem;
    logic [31:0]         r_div;
    logic [31:0]         r_turn;
    logic [63:0]         r_prod;
    logic                r_out_valid;
    logic [31:0]         r_mean;
    logic                r_cin_valid;
    logic                r_cin_vec;
    logic signed [XY_W-1:0] r_cin_x;
    logic signed [XY_W-1:0] r_cin_y;
    logic signed [Z_W-1:0]  r_cin_z;

    t_cord w_link [0:CORDIC_STAGES];

    logic        accept;
    logic [32:0] rem_sh;
    logic        ge;
    logic [31:0] n_rem;
    logic [31:0] abs_s;
    logic [31:0] m_val;
    logic [31:0] pf;
    logic [31:0] p2;
    logic        flip;
    logic signed [XY_W-1:0] xo;
    logic signed [XY_W-1:0] yo;
    logic signed [XY_W-1:0] xr;
    logic signed [XY_W-1:0] yr;
    logic signed [31:0] c_val;
    logic signed [31:0] s_val;
    logic signed [32:0] cs33;
    logic signed [32:0] ss33;
    logic signed [31:0] n_cos;
    logic signed [31:0] n_sin;
    logic signed [XY_W-1:0] vx;
    logic signed [XY_W-1:0] vy;
    logic        out_free;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // divider step: shift in one bit, subtract when it fits
    always_comb begin
        rem_sh = {r_rem, r_div[31]};
        ge     = rem_sh >= {1'b0, r_range};
        n_rem  = ge ? 32'(rem_sh - {1'b0, r_range}) : rem_sh[31:0];
        abs_s  = i_sample[31] ? 32'(-i_sample) : i_sample;
        m_val  = (r_neg && (n_rem != 32'd0)) ? 32'(r_range - n_rem) : n_rem;
    end

    // fold the phase into the right half plane
    always_comb begin
        pf   = {r_div[30:0], ge} + 32'h4000_0000;
        flip = pf[31];
        p2   = flip ? ({r_div[30:0], ge} - 32'h8000_0000) : {r_div[30:0], ge};
    end

    // cordic result to Q16.16 and saturating sums
    always_comb begin
        xo    = w_link[CORDIC_STAGES].x;
        yo    = w_link[CORDIC_STAGES].y;
        xr    = r_flip ? -xo : xo;
        yr    = r_flip ? -yo : yo;
        c_val = 32'((xr + XY_W'(8192)) >>> 14);
        s_val = 32'((yr + XY_W'(8192)) >>> 14);
        cs33  = {r_cos[31], r_cos} + {c_val[31], c_val};
        ss33  = {r_sin[31], r_sin} + {s_val[31], s_val};
        if (cs33[32] != cs33[31]) begin
            n_cos = cs33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_cos = cs33[31:0];
        end
        if (ss33[32] != ss33[31]) begin
            n_sin = ss33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_sin = ss33[31:0];
        end
        vx = $signed({{(XY_W-56){r_cos[31]}}, r_cos, 24'd0});
        vy = $signed({{(XY_W-56){r_sin[31]}}, r_sin, 24'd0});
    end

    // row of cordic cells
    assign w_link[0] = '{valid: r_cin_valid, vec: r_cin_vec,
                         x: r_cin_x, y: r_cin_y, z: r_cin_z};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        cmf_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cord  (w_link[g]),
            .o_cord  (w_link[g+1])
        );
    end

    // control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_range     <= RANGE_RESET;
            r_sin       <= '0;
            r_cos       <= '0;
            r_cnt       <= '0;
            r_cin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cin_valid <= 1'b0;
            if (i_cfg_we) begin
                r_range <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_cnt >= CNT_W'(MAX_FRAME)) begin
                            r_state <= i_last ? S_CHK : S_IDLE;
                        end else if (r_range == 32'd0) begin
                            r_cin_valid <= 1'b1;
                            r_state     <= S_ROT;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (r_step == 5'd31) begin
                        r_state <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    if (r_step == 5'd31) begin
                        r_cin_valid <= 1'b1;
                        r_state     <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (w_link[CORDIC_STAGES].valid) begin
                        r_cos   <= n_cos;
                        r_sin   <= n_sin;
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= r_last ? S_CHK : S_IDLE;
                    end
                end
                S_CHK: begin
                    if ((r_sin == 32'sd0) && (r_cos == 32'sd0)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cin_valid <= 1'b1;
                        r_state     <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (w_link[CORDIC_STAGES].valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_sin       <= '0;
                        r_cos       <= '0;
                        r_cnt       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_last <= i_last;
                r_neg  <= i_sample[31];
                r_step <= 5'd0;
                r_rem  <= 32'd0;
                r_div  <= abs_s;
                r_flip <= 1'b0;
                r_cin_vec <= 1'b0;
                r_cin_x   <= INV_GAIN;
                r_cin_y   <= '0;
                r_cin_z   <= '0;
            end
            S_MOD: begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_rem <= m_val;
                    r_div <= 32'd0;
                end else begin
                    r_rem <= n_rem;
                    r_div <= {r_div[30:0], ge};
                end
            end
            S_FRAC: begin
                r_step <= r_step + 5'd1;
                r_rem  <= n_rem;
                r_div  <= {r_div[30:0], ge};
                if (r_step == 5'd31) begin
                    r_flip    <= flip;
                    r_cin_vec <= 1'b0;
                    r_cin_x   <= INV_GAIN;
                    r_cin_y   <= '0;
                    r_cin_z   <= $signed({{(Z_W-32){p2[31]}}, p2});
                end
            end
            S_CHK: begin
                r_turn    <= 32'd0;
                r_flip    <= 1'b0;
                r_cin_vec <= 1'b1;
                if (r_cos[31]) begin
                    r_cin_x <= -vx;
                    r_cin_y <= -vy;
                    r_cin_z <= Z_W'(34'h0_8000_0000);
                end else begin
                    r_cin_x <= vx;
                    r_cin_y <= vy;
                    r_cin_z <= '0;
                end
            end
            S_VEC: begin
                r_turn <= w_link[CORDIC_STAGES].z[31:0];
            end
            S_MUL: begin
                r_prod <= 64'(r_turn) * 64'(r_range);
            end
            S_OUT: begin
                if (out_free) begin
                    r_mean <= r_prod[63:32];
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_mean      = r_mean;

endmodule

[sv/cmf_cell.sv]
// ----------------------------------------------------------------------------
// cmf_cell
// One cordic micro-rotation, registered; rotation or vectoring per beat.
// ----------------------------------------------------------------------------
module cmf_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cmf_pkg::t_cord i_cord,
    output cmf_pkg::t_cord o_cord
);
    import cmf_pkg::*;

    logic                   r_valid;
    logic                   r_vec;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;

    logic signed [XY_W-1:0] sx;
    logic signed [XY_W-1:0] sy;
    logic signed [Z_W-1:0]  at;
    logic                   dir;

    // shifted terms and rotation direction
    always_comb begin
        sx  = i_cord.x >>> IDX;
        sy  = i_cord.y >>> IDX;
        at  = $signed({2'b00, atan_turn(5'(IDX))});
        dir = i_cord.vec ? i_cord.y[XY_W-1] : ~i_cord.z[Z_W-1];
    end

    // beat marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cord.valid;
        end
    end

    // micro-rotation
    always_ff @(posedge i_clk) begin
        r_vec <= i_cord.vec;
        if (dir) begin
            r_x <= i_cord.x - sy;
            r_y <= i_cord.y + sx;
            r_z <= i_cord.z - at;
        end else begin
            r_x <= i_cord.x + sy;
            r_y <= i_cord.y - sx;
            r_z <= i_cord.z + at;
        end
    end

    assign o_cord = '{valid: r_valid, vec: r_vec, x: r_x, y: r_y, z: r_z};

endmodule
